// ===== src/nrsp_pkg.sv =====
// Package for the RMC sentence parser: field codes, limits, accumulator types
// and the fixed-point constants used when a position is committed.
// Depends on nothing; the parser modules and the testbench import it.
`default_nettype none
package nrsp_pkg;

	localparam int MAX_SENTENCE_BYTES   = 128;
	localparam int MAX_FIELDS           = 15;
	localparam int POSITION_FRAC_DIGITS = 5;
	localparam int MIN_FIELDS           = 12;

	localparam int BP_W    = $clog2(MAX_SENTENCE_BYTES);
	localparam int FIELD_W = $clog2(MAX_FIELDS + 1);
	localparam int MINS_W  = 27;
	localparam int Q_W     = 21;
	localparam int RECIP_K = 33;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	localparam logic [7:0] HEADER [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

	localparam logic [FIELD_W-1:0] F_HEADER = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] F_TIME   = FIELD_W'(1);
	localparam logic [FIELD_W-1:0] F_STATUS = FIELD_W'(2);
	localparam logic [FIELD_W-1:0] F_LAT    = FIELD_W'(3);
	localparam logic [FIELD_W-1:0] F_NS     = FIELD_W'(4);
	localparam logic [FIELD_W-1:0] F_LON    = FIELD_W'(5);
	localparam logic [FIELD_W-1:0] F_EW     = FIELD_W'(6);
	localparam logic [FIELD_W-1:0] F_SPEED  = FIELD_W'(7);
	localparam logic [FIELD_W-1:0] F_COURSE = FIELD_W'(8);
	localparam logic [FIELD_W-1:0] F_DATE   = FIELD_W'(9);

	localparam int SPEED_LIMIT  = 1048575;
	localparam int COURSE_LIMIT = 65535;
	localparam int POS_LIMIT    = 180000000;
	localparam int MAX_DEG      = 180;

	function automatic longint pow10c(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam longint POS_SCALE = pow10c(POSITION_FRAC_DIGITS);
	localparam longint POS_DIV   = 60 * POS_SCALE;
	localparam longint POS_RECIP = ((longint'(1) << RECIP_K) * 1000000 + POS_DIV - 1) / POS_DIV;
	localparam int     RECIP_W   = $clog2(POS_RECIP + 1);
	localparam int     PROD_W    = MINS_W + RECIP_W;

	typedef struct packed {
		logic [7:0]        deg;
		logic              big;
		logic [3:0]        mh;
		logic [3:0]        ml;
		logic [MINS_W-1:0] pad;
		logic [2:0]        fdig;
		logic              dot;
		logic              stop;
	} pos_acc_t;

	typedef struct packed {
		logic [13:0] ip;
		logic        big;
		logic [6:0]  pad;
		logic [1:0]  fdig;
		logic        dot;
		logic        stop;
	} num_acc_t;

	typedef struct packed {
		logic        accepted;
		logic        time_ok;
		logic        date_ok;
		logic        fix;
		logic        lat_ok;
		logic        lon_ok;
		logic        spd_ok;
		logic        crs_ok;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [6:0]  day;
		logic [6:0]  month;
		logic [11:0] year;
		logic [7:0]        lat_deg;
		logic              lat_big;
		logic              lat_neg;
		logic [MINS_W-1:0] lat_mins;
		logic [7:0]        lon_deg;
		logic              lon_big;
		logic              lon_neg;
		logic [MINS_W-1:0] lon_mins;
		logic [19:0] speed;
		logic [15:0] course;
	} snap_t;

endpackage
`default_nettype wire

// ===== src/nrsp_if.sv =====
// Valid/ready channel interfaces of the RMC sentence parser: one for sentence
// bytes and one for parsed records. Depends on nothing.
`default_nettype none
interface nrsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_sentence;
	modport source (output valid, output char_byte, output end_of_sentence, input ready);
	modport sink (input valid, input char_byte, input end_of_sentence, output ready);
endinterface

interface nrsp_fix_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               gps_fix;
	logic [6:0]         hours;
	logic [6:0]         minutes;
	logic [6:0]         seconds;
	logic [6:0]         day;
	logic [6:0]         month;
	logic [11:0]        year;
	logic signed [28:0] latitude;
	logic signed [28:0] longitude;
	logic [19:0]        speed;
	logic [15:0]        course;
	modport source (output valid, output accepted, output gps_fix, output hours,
		output minutes, output seconds, output day, output month, output year,
		output latitude, output longitude, output speed, output course, input ready);
	modport sink (input valid, input accepted, input gps_fix, input hours,
		input minutes, input seconds, input day, input month, input year,
		input latitude, input longitude, input speed, input course, output ready);
endinterface
`default_nettype wire

// ===== src/nrsp_front.sv =====
// Byte stage of the RMC sentence parser: input register, field splitter and
// per-field accumulators, and the sentence snapshot taken on the last byte.
// Depends on nrsp_pkg and nrsp_if.
`default_nettype none
module nrsp_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	nrsp_byte_if.sink   chars,
	output nrsp_pkg::snap_t snap_s2,
	output logic        valid_s2
);
	import nrsp_pkg::*;

	typedef struct packed {
		logic [BP_W-1:0]    bp;
		logic [FIELD_W-1:0] field;
		logic [2:0]         nchr;
		logic               hm;
		logic [5:0][3:0]    tim;
		logic [5:0][3:0]    dat;
		logic               time_ok;
		logic               date_ok;
		logic               fix;
		logic               latn;
		logic               latd;
		logic               lonn;
		logic               lond;
		logic               latneg;
		logic               lonneg;
		logic               spd;
		logic               crs;
		pos_acc_t           lat;
		pos_acc_t           lon;
		num_acc_t           spd_acc;
		num_acc_t           crs_acc;
	} parse_t;

	logic [7:0] char_s1;
	logic       eos_s1;
	logic       valid_s1;
	parse_t     st_q;
	parse_t     nxt;
	parse_t     clr;
	snap_t      snap;

	function automatic logic [MINS_W-1:0] pos_weight(input logic [2:0] f);
		case (f)
			3'd0:    return MINS_W'(pow10c(POSITION_FRAC_DIGITS - 1));
			3'd1:    return MINS_W'(pow10c(POSITION_FRAC_DIGITS - 2));
			3'd2:    return MINS_W'(pow10c(POSITION_FRAC_DIGITS - 3));
			3'd3:    return MINS_W'(pow10c(POSITION_FRAC_DIGITS - 4));
			3'd4:    return MINS_W'(pow10c(POSITION_FRAC_DIGITS - 5));
			default: return MINS_W'(1);
		endcase
	endfunction

	function automatic pos_acc_t pos_char(input pos_acc_t a, input logic [7:0] c);
		pos_acc_t   r;
		logic [3:0] d;
		logic [11:0] nd;
		r  = a;
		d  = 4'(c - CH_ZERO);
		nd = 12'(a.deg) * 12'd10 + 12'(a.mh);
		if (!a.stop) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (!a.dot) begin
					if (!a.big) begin
						if (nd > 12'(MAX_DEG)) begin
							r.big = 1'b1;
						end else begin
							r.deg = nd[7:0];
						end
					end
					r.mh = a.ml;
					r.ml = d;
				end else if (a.fdig < 3'(POSITION_FRAC_DIGITS)) begin
					r.pad  = a.pad + MINS_W'(d) * pos_weight(a.fdig);
					r.fdig = a.fdig + 3'd1;
				end
			end else if (c == CH_DOT && !a.dot) begin
				r.dot = 1'b1;
			end else begin
				r.stop = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic num_acc_t num_char(input num_acc_t a, input logic [7:0] c,
			input logic [13:0] lim);
		num_acc_t   r;
		logic [3:0] d;
		logic [17:0] nip;
		r   = a;
		d   = 4'(c - CH_ZERO);
		nip = 18'(a.ip) * 18'd10 + 18'(d);
		if (!a.stop) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (!a.dot) begin
					if (!a.big) begin
						if (nip > 18'(lim)) begin
							r.big = 1'b1;
						end else begin
							r.ip = nip[13:0];
						end
					end
				end else if (a.fdig < 2'd2) begin
					r.pad  = a.pad + 7'(d) * ((a.fdig == 2'd0) ? 7'd10 : 7'd1);
					r.fdig = a.fdig + 2'd1;
				end
			end else if (c == CH_DOT && !a.dot) begin
				r.dot = 1'b1;
			end else begin
				r.stop = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [20:0] hund(input num_acc_t a);
		return 21'(a.ip) * 21'd100 + 21'(a.pad);
	endfunction

	function automatic logic [3:0] digit(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : 4'd0;
	endfunction

	function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
		return 7'(hi) * 7'd10 + 7'(lo);
	endfunction

	assign chars.ready = en;

	always_comb begin
		clr    = '0;
		clr.hm = 1'b1;
	end

	always_comb begin
		logic        neg;
		logic [20:0] hs;
		logic [20:0] hc;
		logic        hm_f;
		nxt = st_q;
		neg = (char_s1 == CH_S) || (char_s1 == CH_W);
		if (!char_s1[7] && st_q.bp < BP_W'(MAX_SENTENCE_BYTES - 1)) begin
			nxt.bp = st_q.bp + 1'b1;
			if (st_q.field < FIELD_W'(MAX_FIELDS)) begin
				if (char_s1 == CH_COMMA) begin
					if (st_q.field == F_HEADER && st_q.nchr < 3'd6) begin
						nxt.hm = 1'b0;
					end
					nxt.field = st_q.field + 1'b1;
					nxt.nchr  = 3'd0;
				end else begin
					case (st_q.field)
						F_HEADER: begin
							if (st_q.nchr < 3'd6 && char_s1 != HEADER[st_q.nchr]) begin
								nxt.hm = 1'b0;
							end
						end
						F_TIME: begin
							if (st_q.nchr < 3'd6) begin
								nxt.tim[st_q.nchr] = digit(char_s1);
							end
							if (st_q.nchr == 3'd5) begin
								nxt.time_ok = 1'b1;
							end
						end
						F_DATE: begin
							if (st_q.nchr < 3'd6) begin
								nxt.dat[st_q.nchr] = digit(char_s1);
							end
							if (st_q.nchr == 3'd5) begin
								nxt.date_ok = 1'b1;
							end
						end
						F_STATUS: begin
							if (st_q.nchr == 3'd0 && char_s1 == CH_A) begin
								nxt.fix = 1'b1;
							end
						end
						F_LAT: begin
							nxt.latn = 1'b1;
							nxt.lat  = pos_char(st_q.lat, char_s1);
						end
						F_LON: begin
							nxt.lonn = 1'b1;
							nxt.lon  = pos_char(st_q.lon, char_s1);
						end
						F_NS: begin
							if (st_q.nchr == 3'd0) begin
								nxt.latd   = 1'b1;
								nxt.latneg = st_q.latneg | neg;
							end
						end
						F_EW: begin
							if (st_q.nchr == 3'd0) begin
								nxt.lond   = 1'b1;
								nxt.lonneg = st_q.lonneg | neg;
							end
						end
						F_SPEED: begin
							nxt.spd     = 1'b1;
							nxt.spd_acc = num_char(st_q.spd_acc, char_s1,
								14'(SPEED_LIMIT / 100));
						end
						F_COURSE: begin
							nxt.crs     = 1'b1;
							nxt.crs_acc = num_char(st_q.crs_acc, char_s1,
								14'(COURSE_LIMIT / 100));
						end
						default: ;
					endcase
					if (st_q.nchr < 3'd6) begin
						nxt.nchr = st_q.nchr + 3'd1;
					end
				end
			end
		end

		hm_f = nxt.hm && !(nxt.field == F_HEADER && nxt.nchr < 3'd6);
		hs   = hund(nxt.spd_acc);
		hc   = hund(nxt.crs_acc);
		snap.accepted = hm_f && (nxt.field >= FIELD_W'(MIN_FIELDS - 1));
		snap.time_ok  = nxt.time_ok;
		snap.date_ok  = nxt.date_ok;
		snap.fix      = nxt.fix;
		snap.lat_ok   = nxt.latn && nxt.latd;
		snap.lon_ok   = nxt.lonn && nxt.lond;
		snap.spd_ok   = nxt.spd;
		snap.crs_ok   = nxt.crs;
		snap.hours    = pair(nxt.tim[0], nxt.tim[1]);
		snap.minutes  = pair(nxt.tim[2], nxt.tim[3]);
		snap.seconds  = pair(nxt.tim[4], nxt.tim[5]);
		snap.day      = pair(nxt.dat[0], nxt.dat[1]);
		snap.month    = pair(nxt.dat[2], nxt.dat[3]);
		snap.year     = 12'd2000 + 12'(pair(nxt.dat[4], nxt.dat[5]));
		snap.lat_deg  = nxt.lat.deg;
		snap.lat_big  = nxt.lat.big;
		snap.lat_neg  = nxt.latneg;
		snap.lat_mins = MINS_W'(pair(nxt.lat.mh, nxt.lat.ml)) * MINS_W'(POS_SCALE)
			+ nxt.lat.pad;
		snap.lon_deg  = nxt.lon.deg;
		snap.lon_big  = nxt.lon.big;
		snap.lon_neg  = nxt.lonneg;
		snap.lon_mins = MINS_W'(pair(nxt.lon.mh, nxt.lon.ml)) * MINS_W'(POS_SCALE)
			+ nxt.lon.pad;
		snap.speed    = (nxt.spd_acc.big || hs > 21'(SPEED_LIMIT)) ?
			20'(SPEED_LIMIT) : hs[19:0];
		snap.course   = (nxt.crs_acc.big || hc > 21'(COURSE_LIMIT)) ?
			16'(COURSE_LIMIT) : hc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= clr;
		end else if (en) begin
			valid_s1 <= chars.valid;
			valid_s2 <= valid_s1 && eos_s1;
			if (valid_s1) begin
				st_q <= eos_s1 ? clr : nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			char_s1 <= chars.char_byte;
			eos_s1  <= chars.end_of_sentence;
			snap_s2 <= snap;
		end
	end

endmodule
`default_nettype wire

// ===== src/nrsp_commit.sv =====
// Commit stage of the RMC sentence parser: minutes-to-microdegree scaling,
// the held record and the output register. Depends on nrsp_pkg and nrsp_if.
`default_nettype none
module nrsp_commit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire nrsp_pkg::snap_t snap_s2,
	input  wire logic   valid_s2,
	output logic        en,
	nrsp_fix_if.source  fixes
);
	import nrsp_pkg::*;

	snap_t             snap_s3;
	logic              valid_s3;
	logic [PROD_W-1:0] lat_prod_s3;
	logic [PROD_W-1:0] lon_prod_s3;
	logic              out_valid_q;
	logic              acc_q;
	logic              fix_q;
	logic [6:0]        hours_q;
	logic [6:0]        minutes_q;
	logic [6:0]        seconds_q;
	logic [6:0]        day_q;
	logic [6:0]        month_q;
	logic [11:0]       year_q;
	logic signed [28:0] lat_q;
	logic signed [28:0] lon_q;
	logic [19:0]       speed_q;
	logic [15:0]       course_q;

	function automatic logic signed [28:0] pos_final(input logic [7:0] deg,
			input logic big, input logic neg, input logic [PROD_W-1:0] prod);
		logic [28:0] micro;
		micro = 29'(deg) * 29'd1000000 + 29'(prod[RECIP_K +: Q_W]);
		if (big || micro > 29'(POS_LIMIT)) begin
			micro = 29'(POS_LIMIT);
		end
		return neg ? -$signed(micro) : $signed(micro);
	endfunction

	assign en = !out_valid_q || fixes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
			fix_q       <= 1'b0;
			hours_q     <= '0;
			minutes_q   <= '0;
			seconds_q   <= '0;
			day_q       <= '0;
			month_q     <= '0;
			year_q      <= 12'd2000;
			lat_q       <= '0;
			lon_q       <= '0;
			speed_q     <= '0;
			course_q    <= '0;
		end else if (en) begin
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s3) begin
				acc_q <= snap_s3.accepted;
				if (snap_s3.accepted) begin
					fix_q <= snap_s3.fix;
					if (snap_s3.time_ok) begin
						hours_q   <= snap_s3.hours;
						minutes_q <= snap_s3.minutes;
						seconds_q <= snap_s3.seconds;
					end
					if (snap_s3.date_ok) begin
						day_q   <= snap_s3.day;
						month_q <= snap_s3.month;
						year_q  <= snap_s3.year;
					end
					if (snap_s3.lat_ok) begin
						lat_q <= pos_final(snap_s3.lat_deg, snap_s3.lat_big,
							snap_s3.lat_neg, lat_prod_s3);
					end
					if (snap_s3.lon_ok) begin
						lon_q <= pos_final(snap_s3.lon_deg, snap_s3.lon_big,
							snap_s3.lon_neg, lon_prod_s3);
					end
					if (snap_s3.spd_ok) begin
						speed_q <= snap_s3.speed;
					end
					if (snap_s3.crs_ok) begin
						course_q <= snap_s3.course;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snap_s3     <= snap_s2;
			lat_prod_s3 <= PROD_W'(snap_s2.lat_mins) * PROD_W'(POS_RECIP);
			lon_prod_s3 <= PROD_W'(snap_s2.lon_mins) * PROD_W'(POS_RECIP);
		end
	end

	assign fixes.valid     = out_valid_q;
	assign fixes.accepted  = acc_q;
	assign fixes.gps_fix   = fix_q;
	assign fixes.hours     = hours_q;
	assign fixes.minutes   = minutes_q;
	assign fixes.seconds   = seconds_q;
	assign fixes.day       = day_q;
	assign fixes.month     = month_q;
	assign fixes.year      = year_q;
	assign fixes.latitude  = lat_q;
	assign fixes.longitude = lon_q;
	assign fixes.speed     = speed_q;
	assign fixes.course    = course_q;

endmodule
`default_nettype wire

// ===== src/nmea_rmc_sentence_parser.sv =====
// Top level of the RMC sentence parser: byte stage and commit stage.
// Depends on nrsp_pkg, nrsp_if, nrsp_front and nrsp_commit.
//
// Bytes of a sentence arrive on the chars channel, one per beat, with
// end_of_sentence set on the last byte. Each last byte yields one beat on the
// fixes channel with the held record; accepted tells whether this sentence
// passed the header and field count check and was committed.
// The block takes one byte per cycle while a waiting record does not hold it. A
// record passes, after the input register takes its last byte, through byte parse,
// position scaling multiply and record update into the output register.
// Reset clears the parse state and the record, with year set to 2000; the
// block takes bytes from the first cycle after reset.
// While a record waits on a low fixes.ready, the whole pipeline holds and
// chars.ready is low; it resumes in the cycle the record is taken.
`default_nettype none
module nmea_rmc_sentence_parser (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nrsp_byte_if.sink  chars,
	nrsp_fix_if.source fixes
);
	import nrsp_pkg::*;

	snap_t snap_s2;
	logic  valid_s2;
	logic  en;

	nrsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.chars    (chars),
		.snap_s2  (snap_s2),
		.valid_s2 (valid_s2)
	);

	nrsp_commit u_commit (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap_s2  (snap_s2),
		.valid_s2 (valid_s2),
		.en       (en),
		.fixes    (fixes)
	);

endmodule
`default_nettype wire

// ===== sim/nmea_rmc_sentence_parser_tb.sv =====
// Testbench for the RMC sentence parser: streams sentence bytes in, predicts
// each held record in a local model and compares every record beat field by field.
// Depends on nrsp_pkg, nrsp_if and the parser RTL.
`timescale 1ns / 1ps
module nmea_rmc_sentence_parser_tb;
	import nrsp_pkg::*;

	typedef struct {
		logic        accepted;
		logic        gps_fix;
		logic [6:0]  hours, minutes, seconds, day, month;
		logic [11:0] year;
		logic signed [28:0] latitude, longitude;
		logic [19:0] speed;
		logic [15:0] course;
	} fix_rec_t;

	typedef struct {
		longint ip;
		longint frac;
		int     fdig;
		bit     dot;
		bit     stop;
	} num_t;

	logic clk;
	logic arst_n;
	nrsp_byte_if chars ();
	nrsp_fix_if  fixes ();

	nmea_rmc_sentence_parser u_top (.clk(clk), .arst_n(arst_n), .chars(chars), .fixes(fixes));

	initial clk = 1'b0;
	always #6 clk = ~clk;

	fix_rec_t expected_fixes[$];
	int errors = 0;
	int idle_cycles = 0;
	int sentences_sent = 0;
	int records_seen = 0;
	int bytes_sent = 0;

	// Parser model state.
	int  m_pos, m_field, m_chars;
	bit  m_hdr;
	int  m_td[2][6];
	num_t m_ll[2], m_sc[2];
	bit  f_time, f_date, f_fix, f_latn, f_latd, f_lonn, f_lond, f_latneg, f_lonneg, f_spd, f_crs;
	int  r_fix, r_h, r_mi, r_s, r_d, r_mo, r_y;
	longint r_lat, r_lon, r_spd, r_crs;

	function automatic void clear_parse();
		m_pos = 0; m_field = 0; m_chars = 0; m_hdr = 1;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 6; j++) m_td[i][j] = 0;
			m_ll[i] = '{0, 0, 0, 0, 0};
			m_sc[i] = '{0, 0, 0, 0, 0};
		end
		{f_time, f_date, f_fix, f_latn, f_latd, f_lonn, f_lond, f_latneg, f_lonneg, f_spd, f_crs} = '0;
	endfunction

	function automatic void accum_digit(ref num_t a, input int c, input int maxdig);
		if (a.stop) return;
		if (c >= "0" && c <= "9") begin
			if (!a.dot) begin
				a.ip = a.ip * 10 + (c - "0");
				if (a.ip > 99999999) a.ip = 99999999;
			end else if (a.fdig < maxdig) begin
				a.frac = a.frac * 10 + (c - "0");
				a.fdig++;
			end
		end else if (c == "." && !a.dot) a.dot = 1;
		else a.stop = 1;
	endfunction

	function automatic longint frac_scaled(num_t a, int maxdig);
		longint v;
		v = a.frac;
		for (int i = a.fdig; i < maxdig; i++) v = v * 10;
		return v;
	endfunction

	function automatic longint micro_degrees(num_t a, bit neg);
		longint scale, mins, micro;
		scale = 1;
		for (int i = 0; i < POSITION_FRAC_DIGITS; i++) scale = scale * 10;
		mins = (a.ip % 100) * scale + frac_scaled(a, POSITION_FRAC_DIGITS);
		micro = (a.ip / 100) * 1000000 + (mins * 1000000) / (60 * scale);
		if (micro > POS_LIMIT) micro = POS_LIMIT;
		return neg ? -micro : micro;
	endfunction

	function automatic longint hundredths(num_t a, longint lim);
		longint v;
		v = a.ip * 100 + frac_scaled(a, 2);
		return v > lim ? lim : v;
	endfunction

	function automatic void parse_char(int c);
		int n, w;
		bit neg;
		n = m_chars;
		case (m_field)
			0: if (n < 6 && c != HEADER[n]) m_hdr = 0;
			1, 9: begin
				w = (m_field == 1) ? 0 : 1;
				if (n < 6) m_td[w][n] = (c >= "0" && c <= "9") ? c - "0" : 0;
				if (n == 5) begin
					if (w == 0) f_time = 1; else f_date = 1;
				end
			end
			2: if (n == 0 && c == CH_A) f_fix = 1;
			3: begin f_latn = 1; accum_digit(m_ll[0], c, POSITION_FRAC_DIGITS); end
			5: begin f_lonn = 1; accum_digit(m_ll[1], c, POSITION_FRAC_DIGITS); end
			4, 6: if (n == 0) begin
				neg = (c == CH_S || c == CH_W);
				if (m_field == 4) begin f_latd = 1; f_latneg = neg; end
				else begin f_lond = 1; f_lonneg = neg; end
			end
			7: begin f_spd = 1; accum_digit(m_sc[0], c, 2); end
			8: begin f_crs = 1; accum_digit(m_sc[1], c, 2); end
			default: ;
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] c, logic eos);
		int cnt;
		bit acc;
		fix_rec_t e;
		if (c < 128 && m_pos + 1 < MAX_SENTENCE_BYTES) begin
			m_pos++;
			if (m_field < MAX_FIELDS) begin
				if (c == CH_COMMA) begin
					if (m_field == 0 && m_chars < 6) m_hdr = 0;
					m_field++;
					m_chars = 0;
				end else begin
					parse_char(c);
					if (m_chars < 127) m_chars++;
				end
			end
		end
		if (!eos) return;
		if (m_field == 0 && m_chars < 6) m_hdr = 0;
		cnt = (m_field < MAX_FIELDS) ? m_field + 1 : MAX_FIELDS;
		acc = m_hdr && cnt >= MIN_FIELDS;
		if (acc) begin
			if (f_time) begin
				r_h = m_td[0][0] * 10 + m_td[0][1];
				r_mi = m_td[0][2] * 10 + m_td[0][3];
				r_s = m_td[0][4] * 10 + m_td[0][5];
			end
			r_fix = f_fix;
			if (f_latn && f_latd) r_lat = micro_degrees(m_ll[0], f_latneg);
			if (f_lonn && f_lond) r_lon = micro_degrees(m_ll[1], f_lonneg);
			if (f_spd) r_spd = hundredths(m_sc[0], SPEED_LIMIT);
			if (f_crs) r_crs = hundredths(m_sc[1], COURSE_LIMIT);
			if (f_date) begin
				r_d = m_td[1][0] * 10 + m_td[1][1];
				r_mo = m_td[1][2] * 10 + m_td[1][3];
				r_y = 2000 + m_td[1][4] * 10 + m_td[1][5];
			end
		end
		e.accepted = acc; e.gps_fix = r_fix[0];
		e.hours = 7'(r_h); e.minutes = 7'(r_mi); e.seconds = 7'(r_s);
		e.day = 7'(r_d); e.month = 7'(r_mo); e.year = 12'(r_y);
		e.latitude = 29'(r_lat); e.longitude = 29'(r_lon);
		e.speed = 20'(r_spd); e.course = 16'(r_crs);
		expected_fixes.push_back(e);
		clear_parse();
	endfunction

	task automatic send_byte(logic [7:0] c, logic eos);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_byte <= c;
		chars.end_of_sentence <= eos;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		predict_byte(c, eos);
		bytes_sent++;
		if (eos) sentences_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	always @(posedge clk) begin
		if (fixes.valid && fixes.ready) begin
			fix_rec_t e;
			records_seen++;
			if (expected_fixes.size() == 0) begin
				$error("record beat with no expected record");
				errors++;
			end else begin
				e = expected_fixes.pop_front();
				if (fixes.accepted !== e.accepted) begin
					$error("accepted exp %0d got %0d", e.accepted, fixes.accepted); errors++; end
				if (fixes.gps_fix !== e.gps_fix) begin
					$error("gps_fix exp %0d got %0d", e.gps_fix, fixes.gps_fix); errors++; end
				if (fixes.hours !== e.hours) begin
					$error("hours exp %0d got %0d", e.hours, fixes.hours); errors++; end
				if (fixes.minutes !== e.minutes) begin
					$error("minutes exp %0d got %0d", e.minutes, fixes.minutes); errors++; end
				if (fixes.seconds !== e.seconds) begin
					$error("seconds exp %0d got %0d", e.seconds, fixes.seconds); errors++; end
				if (fixes.day !== e.day) begin
					$error("day exp %0d got %0d", e.day, fixes.day); errors++; end
				if (fixes.month !== e.month) begin
					$error("month exp %0d got %0d", e.month, fixes.month); errors++; end
				if (fixes.year !== e.year) begin
					$error("year exp %0d got %0d", e.year, fixes.year); errors++; end
				if (fixes.latitude !== e.latitude) begin
					$error("latitude exp %0d got %0d", e.latitude, fixes.latitude); errors++; end
				if (fixes.longitude !== e.longitude) begin
					$error("longitude exp %0d got %0d", e.longitude, fixes.longitude); errors++; end
				if (fixes.speed !== e.speed) begin
					$error("speed exp %0d got %0d", e.speed, fixes.speed); errors++; end
				if (fixes.course !== e.course) begin
					$error("course exp %0d got %0d", e.course, fixes.course); errors++; end
			end
		end
	end

	// Receiver stalls: per record a random wait, sometimes none.
	int stall_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			fixes.ready <= 1'b0;
			stall_left = 0;
		end else if (fixes.valid && fixes.ready) begin
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			fixes.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			fixes.ready <= (stall_left == 0);
		end else begin
			fixes.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (fixes.valid && fixes.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 2000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic string rand_digits(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_number(int ip_digits, int fr_digits);
		string s;
		s = rand_digits(ip_digits);
		if (fr_digits >= 0) s = {s, ".", rand_digits(fr_digits)};
		return s;
	endfunction

	function automatic string rand_field(int kind);
		case (kind)
			0: return rand_digits($urandom_range(0, 8));
			1: return ($urandom_range(0, 1)) ? "A" : "V";
			2: return rand_number($urandom_range(0, 5), $urandom_range(0, 1) ? -1 : $urandom_range(0, 8));
			3: return ($urandom_range(0, 1)) ? "N" : "S";
			4: return ($urandom_range(0, 1)) ? "E" : "W";
			default: return rand_number($urandom_range(0, 4), $urandom_range(0, 1) ? -1 : $urandom_range(0, 4));
		endcase
	endfunction

	function automatic string random_sentence();
		string s;
		int nf;
		s = ($urandom_range(0, 9) == 0) ? "$GPRMX" : "$GPRMC";
		nf = $urandom_range(0, 9) == 0 ? $urandom_range(5, 18) : 11 + $urandom_range(0, 2);
		for (int f = 1; f <= nf; f++) begin
			string v;
			if ($urandom_range(0, 7) == 0) v = "";
			else case (f)
				1, 9: v = ($urandom_range(0, 5) == 0) ? rand_digits($urandom_range(0, 7))
					: {rand_digits(6), ".", rand_digits($urandom_range(0, 2))};
				2: v = rand_field(1);
				3: v = rand_field(2);
				4: v = rand_field(3);
				5: v = rand_field(2);
				6: v = rand_field(4);
				7, 8: v = rand_field(5);
				default: v = rand_digits($urandom_range(0, 2));
			endcase
			s = {s, ",", v};
		end
		return s;
	endfunction

	task automatic test_directed_sentences();
		send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
		send_text("$GPRMC,235959,V,9959.99999,S,18000.000,W,,,311299,,");
		send_text("$GPRMC,1234,A,,N,0100.00,,99999999.999,99999999.99,0101,,");
		send_text("$GPRMC,000000,,,,,,,,000000,,");
		send_text("$GPRMC,,,,,,");
		send_text("$GPR");
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_special_bytes();
		// High bytes, NUL and non-digits in the time field.
		send_text({"$GPRMC,1a2b3c,A,.5,N,x1,E,1.239,.",
			string'(8'hFF), ",", string'(8'h80), "12,0z0000,,,,,,,,,,,1,2"});
		send_byte(8'hFF, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_long_sentence();
		string s;
		s = "$GPRMC,010203,A,1234.5,S,12345.6,W,1.5,2.5,040506,,";
		while (s.len() < 150) s = {s, "9"};
		send_text(s);
	endtask

	task automatic test_random_sentences();
		while (bytes_sent < 1950) begin
			if ($urandom_range(0, 9) == 0) begin
				int n;
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				send_text(random_sentence());
			end
		end
	endtask

	initial begin
		chars.valid = 1'b0;
		chars.char_byte = 8'h00;
		chars.end_of_sentence = 1'b0;
		clear_parse();
		r_fix = 0; r_h = 0; r_mi = 0; r_s = 0; r_d = 0; r_mo = 0; r_y = 2000;
		r_lat = 0; r_lon = 0; r_spd = 0; r_crs = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_sentences();
		test_special_bytes();
		test_long_sentence();
		test_random_sentences();
		chars.valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d closed sentences; %0d record beats checked.",
			bytes_sent, sentences_sent, records_seen);
		if (errors == 0 && expected_fixes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
